// ===== hw/rtl/sxfb_pkg.sv =====
// Shared types, constants and helpers of the sprite XOR framebuffer.
// Used by the front, back and top-level modules; no dependencies of its own.
package sxfb_pkg;

  // Default screen size and sprite geometry
  localparam int unsigned ScreenWidth  = 64;
  localparam int unsigned ScreenHeight = 32;
  localparam int unsigned SpriteBits   = 8;

  // Depth of the queue between front and back
  localparam int unsigned QueueDepth = 4;

  // Stream data widths, padded to whole bytes
  localparam int unsigned InDataW   = 40;
  localparam int unsigned InUserW   = 2;
  localparam int unsigned LinePixW  = 64;
  localparam int unsigned OutDataW  = 72;

  // Item opcodes
  localparam logic [1:0] OpClear = 2'd0;
  localparam logic [1:0] OpDraw  = 2'd1;
  localparam logic [1:0] OpRead  = 2'd2;

  // Control part of one queued command
  typedef struct packed {
    logic [1:0] op;         // item opcode
    logic       first_row;  // draw with row offset zero
    logic       hit;        // target line lies on the screen
    logic       last;       // final row of a sprite
  } cmd_ctrl_t;

  // Reduce an 8-bit coordinate modulo a screen size of at least 8.
  // Quotient stays below 32, so five compare-subtract steps suffice.
  function automatic logic [7:0] wrap_coord(logic [7:0] v, int unsigned m);
    logic [12:0] r;
    logic [12:0] d;
    r = {5'b0, v};
    for (int k = 4; k >= 0; k--) begin
      d = 13'(m << k);
      if (r >= d) begin
        r = r - d;
      end
    end
    return r[7:0];
  endfunction

endpackage

// ===== hw/rtl/sxfb_queue.sv =====
// Small FIFO between the front and back parts of the framebuffer.
// Depends on nothing but its parameters.
module sxfb_queue #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic [DATA_W-1:0] rdata_o,
  output logic              empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] store_q [DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign rdata_o = store_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== hw/rtl/sxfb_front.sv =====
// Front part: accept input items, wrap coordinates and build the line mask.
// Depends on sxfb_pkg.
module sxfb_front #(
  parameter int unsigned SCREEN_WIDTH  = sxfb_pkg::ScreenWidth,
  parameter int unsigned SCREEN_HEIGHT = sxfb_pkg::ScreenHeight,
  localparam int unsigned AddrW        = $clog2(SCREEN_HEIGHT)
) (
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [sxfb_pkg::InDataW-1:0]   s_axis_tdata_i,
  input  logic [sxfb_pkg::InUserW-1:0]   s_axis_tuser_i,
  input  logic                           s_axis_tlast_i,
  input  logic                           full_i,
  output logic                           push_o,
  output sxfb_pkg::cmd_ctrl_t            ctrl_o,
  output logic [AddrW-1:0]               addr_o,
  output logic [SCREEN_WIDTH-1:0]        mask_o
);

  logic [7:0]              coord_x, coord_y, sprite_byte, pos_x, pos_y;
  logic [3:0]              row_index;
  logic [4:0]              read_line;
  logic [6:0]              line;
  logic                    draw_hit, read_hit;
  logic [7:0]              rev_byte;
  logic [SCREEN_WIDTH+7:0] mask_wide;

  assign coord_x     = s_axis_tdata_i[7:0];
  assign coord_y     = s_axis_tdata_i[15:8];
  assign row_index   = s_axis_tdata_i[19:16];
  assign sprite_byte = s_axis_tdata_i[27:20];
  assign read_line   = s_axis_tdata_i[32:28];

  assign s_axis_tready_o = !full_i;
  assign push_o          = s_axis_tvalid_i && !full_i;

  assign pos_x    = sxfb_pkg::wrap_coord(coord_x, SCREEN_WIDTH);
  assign pos_y    = sxfb_pkg::wrap_coord(coord_y, SCREEN_HEIGHT);
  assign line     = 7'(pos_y) + 7'(row_index);
  assign draw_hit = (line < 7'(SCREEN_HEIGHT));
  assign read_hit = (7'(read_line) < 7'(SCREEN_HEIGHT));

  // Bit 7 of the sprite is the leftmost pixel, i.e. the lowest column
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      rev_byte[j] = sprite_byte[7-j];
    end
  end

  // Pixels shifted past the right edge fall off the top: clipping for free
  assign mask_wide = (SCREEN_WIDTH + 8)'(rev_byte) << pos_x;
  assign mask_o    = mask_wide[SCREEN_WIDTH-1:0];

  always_comb begin
    ctrl_o.op        = s_axis_tuser_i;
    ctrl_o.first_row = (row_index == 4'd0);
    ctrl_o.last      = s_axis_tlast_i;
    if (s_axis_tuser_i == sxfb_pkg::OpRead) begin
      ctrl_o.hit = read_hit;
      addr_o     = AddrW'(read_line);
    end else begin
      ctrl_o.hit = draw_hit;
      addr_o     = AddrW'(line);
    end
  end

endmodule

// ===== hw/rtl/sxfb_back.sv =====
// Back part: framebuffer memory, read-modify-write sequencer and result register.
// Depends on sxfb_pkg.
module sxfb_back #(
  parameter int unsigned SCREEN_WIDTH  = sxfb_pkg::ScreenWidth,
  parameter int unsigned SCREEN_HEIGHT = sxfb_pkg::ScreenHeight,
  localparam int unsigned AddrW        = $clog2(SCREEN_HEIGHT)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          empty_i,
  output logic                          pop_o,
  input  sxfb_pkg::cmd_ctrl_t           ctrl_i,
  input  logic [AddrW-1:0]              addr_i,
  input  logic [SCREEN_WIDTH-1:0]       mask_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [sxfb_pkg::OutDataW-1:0] m_axis_tdata_o,
  output logic                          m_axis_tlast_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StExec = 1'b1;
  localparam int unsigned PadW = sxfb_pkg::OutDataW - sxfb_pkg::LinePixW - 1;

  logic state_q, state_d;

  logic [SCREEN_WIDTH-1:0]  mem_q [SCREEN_HEIGHT];
  logic [SCREEN_WIDTH-1:0]  rd_data_q;
  logic [SCREEN_HEIGHT-1:0] valid_q;

  sxfb_pkg::cmd_ctrl_t      cmd_q;
  logic [AddrW-1:0]         cmd_addr_q;
  logic [SCREEN_WIDTH-1:0]  cmd_mask_q;

  logic                     flag_q, flag_d;
  logic                     out_valid_q;
  logic                     out_coll_q, out_last_q;
  logic [sxfb_pkg::LinePixW-1:0] out_pix_q, pix_d;

  logic                     out_free, exec_go, rd_en, wr_en, clr_en;
  logic [SCREEN_WIDTH-1:0]  cur_line, new_line;

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign pop_o    = (state_q == StIdle) && !empty_i;
  assign rd_en    = pop_o && ctrl_i.hit;
  assign exec_go  = (state_q == StExec) && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (pop_o) state_d = StExec;
      StExec: if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Lines never written since the last clear read as blank
  always_comb begin
    cur_line = '0;
    if (cmd_q.hit && valid_q[cmd_addr_q]) begin
      cur_line = rd_data_q;
    end
  end

  assign new_line = cur_line ^ cmd_mask_q;

  always_comb begin
    flag_d = flag_q;
    pix_d  = '0;
    wr_en  = 1'b0;
    clr_en = 1'b0;
    unique case (cmd_q.op)
      sxfb_pkg::OpClear: clr_en = exec_go;
      sxfb_pkg::OpDraw: begin
        wr_en  = exec_go && cmd_q.hit;
        flag_d = (flag_q && !cmd_q.first_row) ||
                 (cmd_q.hit && (|(cur_line & cmd_mask_q)));
      end
      sxfb_pkg::OpRead: if (cmd_q.hit) pix_d = sxfb_pkg::LinePixW'(cur_line);
      default: flag_d = flag_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      valid_q     <= '0;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (clr_en) begin
        valid_q <= '0;
      end else if (wr_en) begin
        valid_q[cmd_addr_q] <= 1'b1;
      end
      if (exec_go) begin
        flag_q      <= flag_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Memory: one read port with registered data, one write port
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem_q[addr_i];
    end
    if (wr_en) begin
      mem_q[cmd_addr_q] <= new_line;
    end
  end

  // Command and result payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q      <= ctrl_i;
      cmd_addr_q <= addr_i;
      cmd_mask_q <= mask_i;
    end
    if (exec_go) begin
      out_coll_q <= flag_d;
      out_pix_q  <= pix_d;
      out_last_q <= cmd_q.last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {PadW'(0), out_pix_q, out_coll_q};
  assign m_axis_tlast_o  = out_last_q;

endmodule

// ===== hw/rtl/sprite_xor_framebuffer.sv =====
// Top level of the sprite XOR framebuffer: front, command queue and back.
// Depends on sxfb_pkg, sxfb_front, sxfb_queue and sxfb_back.
//
//  channel  | dir | tdata (low bit up)                               | tuser  | tlast
//  s_axis   | in  | coord_x, coord_y, row_index, sprite_byte,        | opcode | last_row
//           |     | read_line, zero pad to 40 bits                   |        |
//  m_axis   | out | collision, line_pixels, zero pad to 72 bits      | -      | last_row
//
// Flow: the front decodes an item in the cycle it is accepted and pushes it into a
// four-entry queue. The back handles each item in two steps: pop and framebuffer read,
// then modify-write and loading of the result register, which waits while the output
// still holds a result. The read-modify-write of a framebuffer line does not overlap
// from one item to the next: the back pops a new item only once the last is through.
// Reset: per-line valid bits clear at once, so the framebuffer reads blank straight
// after reset and after a clear item; no clearing pass is needed.
// Stalls: a held result stalls only the back; the front keeps accepting until the
// queue fills.
module sprite_xor_framebuffer #(
  parameter int unsigned SCREEN_WIDTH  = sxfb_pkg::ScreenWidth,
  parameter int unsigned SCREEN_HEIGHT = sxfb_pkg::ScreenHeight
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // coord_x[7:0], coord_y[15:8], row_index[19:16], sprite_byte[27:20], read_line[32:28]
  input  logic [sxfb_pkg::InDataW-1:0]  s_axis_tdata_i,
  // opcode[1:0]
  input  logic [sxfb_pkg::InUserW-1:0]  s_axis_tuser_i,
  input  logic                          s_axis_tlast_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // collision[0], line_pixels[64:1]
  output logic [sxfb_pkg::OutDataW-1:0] m_axis_tdata_o,
  output logic                          m_axis_tlast_o
);

  localparam int unsigned AddrW = $clog2(SCREEN_HEIGHT);
  localparam int unsigned CtrlW = $bits(sxfb_pkg::cmd_ctrl_t);
  localparam int unsigned QW    = CtrlW + AddrW + SCREEN_WIDTH;

  // Front to queue
  logic                    f_push;
  sxfb_pkg::cmd_ctrl_t     f_ctrl;
  logic [AddrW-1:0]        f_addr;
  logic [SCREEN_WIDTH-1:0] f_mask;
  logic                    q_full;

  // Queue to back
  logic [QW-1:0]           q_wdata, q_rdata;
  logic                    q_empty, b_pop;
  sxfb_pkg::cmd_ctrl_t     b_ctrl;
  logic [AddrW-1:0]        b_addr;
  logic [SCREEN_WIDTH-1:0] b_mask;

  sxfb_front #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_front (
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .full_i         (q_full),
    .push_o         (f_push),
    .ctrl_o         (f_ctrl),
    .addr_o         (f_addr),
    .mask_o         (f_mask)
  );

  // Pack the decoded command: control on top, then line address, then pixel mask
  assign q_wdata = {f_ctrl, f_addr, f_mask};

  sxfb_queue #(
    .DATA_W(QW),
    .DEPTH (sxfb_pkg::QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (f_push),
    .wdata_i(q_wdata),
    .full_o (q_full),
    .pop_i  (b_pop),
    .rdata_o(q_rdata),
    .empty_o(q_empty)
  );

  assign b_ctrl = sxfb_pkg::cmd_ctrl_t'(q_rdata[QW-1 -: CtrlW]);
  assign b_addr = q_rdata[SCREEN_WIDTH +: AddrW];
  assign b_mask = q_rdata[SCREEN_WIDTH-1:0];

  sxfb_back #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (q_empty),
    .pop_o          (b_pop),
    .ctrl_i         (b_ctrl),
    .addr_i         (b_addr),
    .mask_i         (b_mask),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

endmodule
